>>> design/cnel_pkg.sv
// shared types, constants and codes of the cpio newc entry lister
`timescale 1ns / 1ps

package cnel_pkg;

  localparam int unsigned HEADER_BYTES    = 110;
  localparam int unsigned PREFIX_BYTES_DEF = 10;
  localparam int unsigned PREFIX_BYTES_MAX = 16;
  localparam int unsigned TRAIL_LEN       = 10;
  localparam int unsigned MAGIC_LEN       = 6;
  localparam int unsigned QUEUE_DEPTH     = 4;

  // wide enough for any prefix length in range
  localparam int unsigned CNT_W  = $clog2(PREFIX_BYTES_MAX + 1);
  localparam int unsigned PIDX_W = $clog2(PREFIX_BYTES_MAX);

  // header field offsets
  localparam int unsigned FSIZE_FIRST = 54;
  localparam int unsigned FSIZE_LAST  = 61;
  localparam int unsigned NSIZE_FIRST = 94;
  localparam int unsigned NSIZE_LAST  = 101;

  localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{
    8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31
  };

  localparam logic [7:0] TRAIL_TEXT [TRAIL_LEN] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
  };

  typedef enum logic [1:0] {
    KIND_SIZE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_PAD1   = 3'd2,
    PH_DATA   = 3'd3,
    PH_PAD2   = 3'd4,
    PH_HALT   = 3'd5
  } phase_e;

  // one queued job: a single result, or a size result plus held name characters
  typedef struct packed {
    logic             burst;
    kind_e            kind;
    logic [31:0]      fsize;
    logic [7:0]       ch;
    logic             done;
    logic [CNT_W-1:0] cnt;
    logic             char_done;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [7:0]        data;
  } pfx_wr_t;

endpackage

>>> design/cpio_newc_entry_lister_top.sv
// top level of the cpio newc entry lister
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o   data_byte_i
//   out      source     out_valid_o/out_ready_i kind_o file_size_o name_char_o
//                                               name_done_o run_last_o
//
// one archive byte per cycle in, one result per cycle out, each while not stalled
// a byte that ends the name prefix causes up to PREFIX_BYTES+1 results, drained
// at one per cycle by the sequencer while not stalled; the next entry's name
// stalls input until done; parser and sequencer are parted by a four-job queue,
// each stalls on its own; rst_ni clears all control state; no clearing pass
`timescale 1ns / 1ps

module cpio_newc_entry_lister_top #(
  parameter int unsigned PREFIX_BYTES = cnel_pkg::PREFIX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] file_size_o,
  output logic [7:0]  name_char_o,
  output logic        name_done_o,
  output logic        run_last_o
);

  cnel_pkg::job_t    push_job;
  cnel_pkg::job_t    head_job;
  cnel_pkg::pfx_wr_t pfx_wr;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic              burst_done;

  cnel_front #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job),
    .pfx_wr_o    (pfx_wr),
    .burst_done_i(burst_done)
  );

  cnel_queue #(
    .DEPTH(cnel_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  cnel_back #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .pfx_wr_i    (pfx_wr),
    .burst_done_o(burst_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .file_size_o (file_size_o),
    .name_char_o (name_char_o),
    .name_done_o (name_done_o),
    .run_last_o  (run_last_o)
  );

endmodule

>>> design/cnel_front.sv
// byte parser: header, name, padding and data phases, job generation
`timescale 1ns / 1ps

module cnel_front #(
  parameter int unsigned PREFIX_BYTES = cnel_pkg::PREFIX_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cnel_pkg::job_t     job_o,
  output cnel_pkg::pfx_wr_t  pfx_wr_o,
  input  logic               burst_done_i
);

  localparam int unsigned CMP_LEN =
    (PREFIX_BYTES < cnel_pkg::TRAIL_LEN) ? PREFIX_BYTES : cnel_pkg::TRAIL_LEN;

  cnel_pkg::phase_e phase_q, phase_d;
  logic [31:0] bc_q, bc_d;
  logic [31:0] hex_q, hex_d;
  logic        stop_q, stop_d;
  logic [31:0] fsize_q, fsize_d;
  logic [31:0] nsize_q, nsize_d;
  logic        match_q, match_d;
  logic [1:0]  align_q, align_d;
  logic        pend_q, pend_d;

  logic        accept;
  logic        block;
  logic        match_n;
  logic [31:0] acc;
  logic        stp;
  logic        in_field;
  logic [31:0] dpt;

  assign block      = (phase_q == cnel_pkg::PH_NAME) && (bc_q < 32'(PREFIX_BYTES)) && pend_q;
  assign in_ready_o = !q_full_i && !block;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    bc_d     = bc_q;
    hex_d    = hex_q;
    stop_d   = stop_q;
    fsize_d  = fsize_q;
    nsize_d  = nsize_q;
    match_d  = match_q;
    align_d  = align_q;
    pend_d   = pend_q;
    push_o   = 1'b0;
    job_o    = '0;
    pfx_wr_o = '0;
    match_n  = match_q;
    acc      = hex_q;
    stp      = stop_q;
    in_field = 1'b0;
    dpt      = (nsize_q < 32'(PREFIX_BYTES)) ? nsize_q : 32'(PREFIX_BYTES);

    if (burst_done_i) begin
      pend_d = 1'b0;
    end

    if (accept && phase_q != cnel_pkg::PH_HALT) begin
      align_d = align_q + 2'd1;
      unique case (phase_q)
        cnel_pkg::PH_HEADER: begin
          if (bc_q < 32'(cnel_pkg::MAGIC_LEN) &&
              data_byte_i != cnel_pkg::MAGIC_TEXT[bc_q[2:0]]) begin
            match_n = 1'b0;
          end
          if (bc_q == 32'(cnel_pkg::MAGIC_LEN - 1) && !match_n) begin
            push_o     = 1'b1;
            job_o.kind = cnel_pkg::KIND_BAD;
            phase_d    = cnel_pkg::PH_HALT;
            match_d    = match_n;
          end else begin
            if (bc_q == 32'(cnel_pkg::FSIZE_FIRST) || bc_q == 32'(cnel_pkg::NSIZE_FIRST)) begin
              acc = '0;
              stp = 1'b0;
            end
            in_field =
              (bc_q >= 32'(cnel_pkg::FSIZE_FIRST) && bc_q <= 32'(cnel_pkg::FSIZE_LAST)) ||
              (bc_q >= 32'(cnel_pkg::NSIZE_FIRST) && bc_q <= 32'(cnel_pkg::NSIZE_LAST));
            if (in_field && !stp) begin
              if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
                acc = {acc[27:0], 4'(data_byte_i - 8'h30)};
              end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
                acc = {acc[27:0], 4'(data_byte_i - 8'h37)};
              end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
                acc = {acc[27:0], 4'(data_byte_i - 8'h57)};
              end else if (data_byte_i == 8'h00) begin
                stp = 1'b1;
              end else begin
                acc = '0;
                stp = 1'b1;
              end
            end
            hex_d  = acc;
            stop_d = stp;
            if (bc_q == 32'(cnel_pkg::FSIZE_LAST)) begin
              fsize_d = acc;
            end
            if (bc_q == 32'(cnel_pkg::NSIZE_LAST)) begin
              nsize_d = acc;
            end
            if (bc_q == 32'(cnel_pkg::HEADER_BYTES - 1)) begin
              match_d = 1'b1;
              bc_d    = '0;
              if (nsize_q == '0) begin
                push_o      = 1'b1;
                job_o.kind  = cnel_pkg::KIND_SIZE;
                job_o.fsize = fsize_q;
                job_o.done  = 1'b1;
                if (align_d != 2'd0) begin
                  phase_d = cnel_pkg::PH_PAD1;
                end else if (fsize_q != '0) begin
                  phase_d = cnel_pkg::PH_DATA;
                end
              end else begin
                phase_d = cnel_pkg::PH_NAME;
              end
            end else begin
              match_d = match_n;
              bc_d    = bc_q + 32'd1;
            end
          end
        end
        cnel_pkg::PH_NAME: begin
          if (bc_q < 32'(PREFIX_BYTES)) begin
            pfx_wr_o.en   = 1'b1;
            pfx_wr_o.idx  = bc_q[cnel_pkg::PIDX_W-1:0];
            pfx_wr_o.data = data_byte_i;
          end
          if (bc_q < 32'(CMP_LEN) && data_byte_i != cnel_pkg::TRAIL_TEXT[bc_q[3:0]]) begin
            match_n = 1'b0;
          end
          match_d = match_n;
          if (bc_q == dpt - 32'd1) begin
            push_o      = 1'b1;
            job_o.fsize = fsize_q;
            if (nsize_q >= 32'(CMP_LEN) && match_n) begin
              job_o.kind = cnel_pkg::KIND_END;
              phase_d    = cnel_pkg::PH_HALT;
            end else begin
              job_o.kind      = cnel_pkg::KIND_SIZE;
              job_o.burst     = 1'b1;
              job_o.done      = (nsize_q <= 32'd1);
              job_o.char_done = (nsize_q <= 32'(PREFIX_BYTES + 1));
              job_o.cnt       = (nsize_q <= 32'(PREFIX_BYTES)) ?
                                cnel_pkg::CNT_W'(nsize_q - 32'd1) :
                                cnel_pkg::CNT_W'(PREFIX_BYTES);
              pend_d          = 1'b1;
            end
          end else if (bc_q >= dpt && bc_q < nsize_q - 32'd1) begin
            push_o      = 1'b1;
            job_o.kind  = cnel_pkg::KIND_CHAR;
            job_o.fsize = fsize_q;
            job_o.ch    = data_byte_i;
            job_o.done  = (bc_q == nsize_q - 32'd2);
          end
          if (phase_d != cnel_pkg::PH_HALT) begin
            if (bc_q == nsize_q - 32'd1) begin
              bc_d = '0;
              if (align_d != 2'd0) begin
                phase_d = cnel_pkg::PH_PAD1;
              end else if (fsize_q != '0) begin
                phase_d = cnel_pkg::PH_DATA;
              end else begin
                phase_d = cnel_pkg::PH_HEADER;
              end
            end else begin
              bc_d = bc_q + 32'd1;
            end
          end
        end
        cnel_pkg::PH_PAD1: begin
          if (align_d == 2'd0) begin
            bc_d    = '0;
            phase_d = (fsize_q != '0) ? cnel_pkg::PH_DATA : cnel_pkg::PH_HEADER;
          end
        end
        cnel_pkg::PH_DATA: begin
          if (bc_q == fsize_q - 32'd1) begin
            bc_d    = '0;
            phase_d = (align_d != 2'd0) ? cnel_pkg::PH_PAD2 : cnel_pkg::PH_HEADER;
          end else begin
            bc_d = bc_q + 32'd1;
          end
        end
        cnel_pkg::PH_PAD2: begin
          if (align_d == 2'd0) begin
            phase_d = cnel_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_d = cnel_pkg::PH_HALT;
        end
      endcase

      // start of a new header
      if (phase_d == cnel_pkg::PH_HEADER && phase_q != cnel_pkg::PH_HEADER) begin
        bc_d    = '0;
        match_d = 1'b1;
        hex_d   = '0;
        stop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cnel_pkg::PH_HEADER;
      bc_q    <= '0;
      hex_q   <= '0;
      stop_q  <= 1'b0;
      fsize_q <= '0;
      nsize_q <= '0;
      match_q <= 1'b1;
      align_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      hex_q   <= hex_d;
      stop_q  <= stop_d;
      fsize_q <= fsize_d;
      nsize_q <= nsize_d;
      match_q <= match_d;
      align_q <= align_d;
      pend_q  <= pend_d;
    end
  end

endmodule

>>> design/cnel_queue.sv
// short job queue between parser and result sequencer
`timescale 1ns / 1ps

module cnel_queue #(
  parameter int unsigned DEPTH = cnel_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cnel_pkg::job_t job_i,
  input  logic           pop_i,
  output cnel_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cnel_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d;
  logic [AW-1:0]  rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/cnel_back.sv
// result sequencer: expands jobs into result transfers, holds the name prefix
`timescale 1ns / 1ps

module cnel_back #(
  parameter int unsigned PREFIX_BYTES = cnel_pkg::PREFIX_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cnel_pkg::job_t    job_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  input  cnel_pkg::pfx_wr_t pfx_wr_i,
  output logic              burst_done_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [31:0]       file_size_o,
  output logic [7:0]        name_char_o,
  output logic              name_done_o,
  output logic              run_last_o
);

  localparam int unsigned IW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

  logic [7:0]                 pfx_q [PREFIX_BYTES];
  cnel_pkg::job_t             job_q;
  logic                       act_q;
  logic [cnel_pkg::CNT_W-1:0] pos_q;
  logic [cnel_pkg::CNT_W-1:0] idx;
  logic                       last;
  logic                       xfer;
  logic                       is_char;

  assign last    = (pos_q == job_q.cnt);
  assign xfer    = act_q && out_ready_i;
  assign pop_o   = !q_empty_i && (!act_q || (out_ready_i && last));
  assign idx     = pos_q - cnel_pkg::CNT_W'(1);
  assign is_char = job_q.burst && (pos_q != '0);

  assign burst_done_o = xfer && last && job_q.burst;
  assign out_valid_o  = act_q;
  assign file_size_o  = job_q.fsize;
  assign run_last_o   = last;

  always_comb begin
    if (is_char) begin
      kind_o      = cnel_pkg::KIND_CHAR;
      name_char_o = pfx_q[idx[IW-1:0]];
      name_done_o = job_q.char_done && last;
    end else begin
      kind_o      = job_q.kind;
      name_char_o = job_q.ch;
      name_done_o = job_q.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pfx_wr_i.en) begin
      pfx_q[pfx_wr_i.idx[IW-1:0]] <= pfx_wr_i.data;
    end
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pos_q <= '0;
    end else if (pop_o) begin
      act_q <= 1'b1;
      pos_q <= '0;
    end else if (xfer && last) begin
      act_q <= 1'b0;
    end else if (xfer) begin
      pos_q <= pos_q + cnel_pkg::CNT_W'(1);
    end
  end

endmodule

>>> design/cnel_checker.sv
// port-level checks of the entry lister and their bind
`timescale 1ns / 1ps

module cnel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] file_size_o,
  input logic [7:0]  name_char_o,
  input logic        name_done_o,
  input logic        run_last_o
);

  logic halted_q;
  logic stop_xfer;

  assign stop_xfer = out_valid_o && out_ready_i &&
                     (kind_o == cnel_pkg::KIND_END || kind_o == cnel_pkg::KIND_BAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else if (stop_xfer) begin
      halted_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(file_size_o) && $stable(name_char_o) && $stable(name_done_o) &&
      $stable(run_last_o))
    else $error("result changed while stalled");

  a_stop_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == cnel_pkg::KIND_END || kind_o == cnel_pkg::KIND_BAD)
      |-> !name_done_o && run_last_o)
    else $error("end or bad magic result malformed");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cnel_pkg::KIND_BAD |-> file_size_o == '0)
    else $error("bad magic result carries a size");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_done_o |-> run_last_o)
    else $error("name end not last result of its byte");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !out_valid_o)
    else $error("result after end of archive");

endmodule

bind cpio_newc_entry_lister_top cnel_checker u_cnel_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .data_byte_i(data_byte_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .kind_o     (kind_o),
  .file_size_o(file_size_o),
  .name_char_o(name_char_o),
  .name_done_o(name_done_o),
  .run_last_o (run_last_o)
);
